/* rtl/core/oiol_pkg.sv */
package oiol_pkg;

  localparam int OIOL_MAX_WIDTH    = 1024;
  localparam int OIOL_ID_BITS      = 8;
  localparam int OIOL_CH_W         = 8;
  localparam int OIOL_RGB_W        = 24;
  localparam int OIOL_SEL_BIT      = 24;
  localparam int OIOL_FW_W         = 11;
  localparam int OIOL_H_W          = 13;
  localparam int OIOL_HEIGHT_LIMIT = 4096;
  localparam int OIOL_MIN_SIZE     = 3;
  localparam int OIOL_CFG_IDX_W    = 2;
  localparam int OIOL_CFG_W        = 24;
  localparam int OIOL_QDEPTH       = 4;

  localparam logic [OIOL_RGB_W-1:0] OIOL_GRAY_RGB      = 24'h191919;
  localparam logic [OIOL_RGB_W-1:0] OIOL_HIGHLIGHT_RST = 24'h00FFFF;

  typedef enum logic [1:0] {
    QK_STEP,
    QK_FIX_OLD,
    QK_FIX_NEW
  } oiol_kind_t;

  typedef struct packed {
    oiol_kind_t kind;
    logic       emit;
    logic       last;
    logic [2:0] row_in;
    logic [2:0] col_in;
  } oiol_ctrl_t;

  typedef struct packed {
    logic                  outline_disable;
    logic [OIOL_RGB_W-1:0] highlight_color;
  } oiol_look_t;

endpackage

/* rtl/core/oiol_ifs.sv */
interface oiol_pix_in_if import oiol_pkg::*; #(
  parameter int ID_BITS = OIOL_ID_BITS
);
  logic                 valid;
  logic                 ready;
  logic [ID_BITS-1:0]   object_id;
  logic                 is_selected;
  logic [OIOL_CH_W-1:0] red_in;
  logic [OIOL_CH_W-1:0] green_in;
  logic [OIOL_CH_W-1:0] blue_in;
  logic                 flush;

  modport source (
    output valid, object_id, is_selected, red_in, green_in, blue_in, flush,
    input  ready
  );
  modport sink (
    input  valid, object_id, is_selected, red_in, green_in, blue_in, flush,
    output ready
  );
endinterface

interface oiol_pix_out_if import oiol_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OIOL_CH_W-1:0] red_out;
  logic [OIOL_CH_W-1:0] green_out;
  logic [OIOL_CH_W-1:0] blue_out;
  logic                 frame_end;

  modport source (
    output valid, red_out, green_out, blue_out, frame_end,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, frame_end,
    output ready
  );
endinterface

/* rtl/core/oiol_front.sv */
module oiol_front import oiol_pkg::*; #(
  parameter  int MAX_WIDTH = OIOL_MAX_WIDTH,
  parameter  int ID_BITS   = OIOL_ID_BITS,
  localparam int ENTRY_W   = ID_BITS + OIOL_RGB_W + 1,
  localparam int CNT_W     = $clog2(OIOL_QDEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  oiol_pix_in_if.sink               in_pix,
  input  logic                      cfg_we,
  input  logic [OIOL_CFG_IDX_W-1:0] cfg_index,
  input  logic [OIOL_CFG_W-1:0]     cfg_data,
  input  logic [CNT_W-1:0]          q_count,
  output logic                      push_valid,
  output oiol_ctrl_t                push_ctrl,
  output logic [ENTRY_W-1:0]        push_top,
  output logic [ENTRY_W-1:0]        push_mid,
  output logic [ENTRY_W-1:0]        push_bot,
  output oiol_look_t                look
);

  localparam int RING_LEN = 2 * MAX_WIDTH + 3;
  localparam int AW       = $clog2(RING_LEN);
  localparam int WB       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = OIOL_H_W;

  typedef enum logic [OIOL_CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_OUTLINE_DISABLE,
    REG_HIGHLIGHT_COLOR
  } reg_idx_t;

  typedef enum logic [1:0] {
    PR_IDLE,
    PR_OLD,
    PR_NEW
  } prime_t;

  logic [OIOL_FW_W-1:0]  frame_width_r;
  logic [HW-1:0]         frame_height_r;
  logic                  outline_disable_r;
  logic [OIOL_RGB_W-1:0] highlight_color_r;
  prime_t                prime_r;

  logic [WB-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [AW-1:0] wp_r, wp_nxt;

  logic [ENTRY_W-1:0] ring_mem [RING_LEN];
  logic [ENTRY_W-1:0] rd_top_r, rd_mid_r;
  logic               s1_valid_r;
  oiol_ctrl_t         s1_ctrl_r;
  logic [ENTRY_W-1:0] s1_bot_r;

  logic [WB-1:0]      w_eff, ec;
  logic [HW-1:0]      h_eff, er;
  logic [WB:0]        ecx, wx;
  logic               col_nz, er_ok, drop, emit, last, in_frame;
  logic [2:0]         row_in, col_in;
  logic [ENTRY_W-1:0] entry;
  logic               room, accept, prime_go, step_go, rd_en;
  logic [AW-1:0]      back_k, off_mid, off_top, addr_mid, addr_top;
  oiol_ctrl_t         ctrl_nxt;

  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                               input logic [AW-1:0] off);
    logic [AW:0] d;
    d = {1'b0, pos} - {1'b0, off};
    if (d[AW]) d = d + (AW+1)'(RING_LEN);
    return d[AW-1:0];
  endfunction

  always_comb begin
    if (frame_width_r < OIOL_FW_W'(OIOL_MIN_SIZE)) w_eff = WB'(OIOL_MIN_SIZE);
    else if (int'(frame_width_r) > MAX_WIDTH)     w_eff = WB'(MAX_WIDTH);
    else                                           w_eff = WB'(frame_width_r);
    if (frame_height_r < HW'(OIOL_MIN_SIZE))            h_eff = HW'(OIOL_MIN_SIZE);
    else if (int'(frame_height_r) > OIOL_HEIGHT_LIMIT) h_eff = HW'(OIOL_HEIGHT_LIMIT);
    else                                                h_eff = frame_height_r;
  end

  always_comb begin
    col_nz   = col_r != '0;
    er_ok    = col_nz ? (row_r >= HW'(1)) : (row_r >= HW'(2));
    er       = col_nz ? row_r - HW'(1) : row_r - HW'(2);
    ec       = col_nz ? col_r - WB'(1) : w_eff - WB'(1);
    ecx      = {1'b0, ec};
    wx       = {1'b0, w_eff};
    drop     = er_ok && (er >= h_eff || ec >= w_eff);
    emit     = er_ok && !drop;
    last     = emit && (er == h_eff - HW'(1)) && (ec == w_eff - WB'(1));
    in_frame = (row_r < h_eff) && (col_r < w_eff);

    row_in[0] = er >= HW'(2);
    row_in[1] = (er >= HW'(1)) && (er + HW'(2) <= h_eff);
    row_in[2] = er + HW'(3) <= h_eff;
    col_in[0] = ec >= WB'(2);
    col_in[1] = (ec >= WB'(1)) && (ecx + (WB+1)'(2) <= wx);
    col_in[2] = ecx + (WB+1)'(3) <= wx;

    if (!in_pix.flush && in_frame) begin
      entry = {in_pix.object_id, in_pix.is_selected,
               in_pix.red_in, in_pix.green_in, in_pix.blue_in};
    end else begin
      entry = '0;
    end
  end

  assign room         = (int'(q_count) + int'(s1_valid_r)) < OIOL_QDEPTH;
  assign in_pix.ready = (prime_r == PR_IDLE) && room;
  assign accept       = in_pix.valid && in_pix.ready;
  assign prime_go     = (prime_r != PR_IDLE) && room;
  assign step_go      = accept && !drop;
  assign rd_en        = step_go || prime_go;

  always_comb begin
    back_k = '0;
    if (prime_r == PR_OLD)      back_k = AW'(2);
    else if (prime_r == PR_NEW) back_k = AW'(1);
    off_mid  = AW'(w_eff) + back_k;
    off_top  = off_mid + AW'(w_eff);
    addr_mid = ring_back(wp_r, off_mid);
    addr_top = ring_back(wp_r, off_top);

    ctrl_nxt.kind   = QK_STEP;
    ctrl_nxt.emit   = emit;
    ctrl_nxt.last   = last;
    ctrl_nxt.row_in = row_in;
    ctrl_nxt.col_in = col_in;
    if (prime_go) begin
      ctrl_nxt.kind = (prime_r == PR_OLD) ? QK_FIX_OLD : QK_FIX_NEW;
      ctrl_nxt.emit = 1'b0;
      ctrl_nxt.last = 1'b0;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    wp_nxt  = wp_r;
    if (accept) begin
      if (drop || last) begin
        col_nxt = '0;
        row_nxt = '0;
        wp_nxt  = '0;
      end else begin
        wp_nxt = (wp_r == AW'(RING_LEN - 1)) ? '0 : wp_r + AW'(1);
        if ({1'b0, col_r} + (WB+1)'(1) >= wx) begin
          col_nxt = '0;
          row_nxt = row_r + HW'(1);
        end else begin
          col_nxt = col_r + WB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= OIOL_FW_W'(640);
      frame_height_r    <= HW'(480);
      outline_disable_r <= 1'b0;
      highlight_color_r <= OIOL_HIGHLIGHT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:     frame_width_r     <= cfg_data[OIOL_FW_W-1:0];
        REG_FRAME_HEIGHT:    frame_height_r    <= cfg_data[HW-1:0];
        REG_OUTLINE_DISABLE: outline_disable_r <= cfg_data[0];
        REG_HIGHLIGHT_COLOR: highlight_color_r <= cfg_data[OIOL_RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= PR_IDLE;
    end else if (cfg_we && reg_idx_t'(cfg_index) == REG_FRAME_WIDTH) begin
      prime_r <= PR_OLD;
    end else begin
      unique case (prime_r)
        PR_IDLE: prime_r <= PR_IDLE;
        PR_OLD:  if (room) prime_r <= PR_NEW;
        PR_NEW:  if (room) prime_r <= PR_IDLE;
        default: prime_r <= PR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      wp_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      wp_r       <= wp_nxt;
      s1_valid_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) ring_mem[wp_r] <= entry;
    if (rd_en) begin
      rd_top_r <= ring_mem[addr_top];
      rd_mid_r <= ring_mem[addr_mid];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_ctrl_r <= ctrl_nxt;
      s1_bot_r  <= entry;
    end
  end

  assign push_valid = s1_valid_r;
  assign push_ctrl  = s1_ctrl_r;
  assign push_top   = rd_top_r;
  assign push_mid   = rd_mid_r;
  assign push_bot   = s1_bot_r;

  assign look.outline_disable = outline_disable_r;
  assign look.highlight_color = highlight_color_r;

endmodule

/* rtl/core/oiol_queue.sv */
module oiol_queue import oiol_pkg::*; #(
  parameter  int DATA_W = 1,
  parameter  int DEPTH  = OIOL_QDEPTH,
  localparam int PW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              head_valid,
  output logic [CNT_W-1:0]  count
);

  logic [DATA_W-1:0] slots_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (!push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  assign head_data  = slots_r[rd_ptr_r];
  assign head_valid = count_r != '0;
  assign count      = count_r;

endmodule

/* rtl/core/oiol_back.sv */
module oiol_back import oiol_pkg::*; #(
  parameter  int ID_BITS = OIOL_ID_BITS,
  localparam int ENTRY_W = ID_BITS + OIOL_RGB_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  oiol_ctrl_t         head_ctrl,
  input  logic [ENTRY_W-1:0] head_top,
  input  logic [ENTRY_W-1:0] head_mid,
  input  logic [ENTRY_W-1:0] head_bot,
  output logic               pop,
  input  oiol_look_t         look,
  oiol_pix_out_if.source     out_pix
);

  logic [ENTRY_W-1:0]    win_r [2][3];
  logic [ENTRY_W-1:0]    nb [3][3];
  logic                  out_valid_r;
  logic [OIOL_CH_W-1:0]  red_r, green_r, blue_r;
  logic                  frame_end_r;

  logic [ID_BITS-1:0]    cid;
  logic                  csel, gray, high, emit_go;
  logic [OIOL_RGB_W-1:0] rgb;

  function automatic logic [ID_BITS-1:0] id_of(input logic [ENTRY_W-1:0] e);
    return e[ENTRY_W-1 -: ID_BITS];
  endfunction

  function automatic logic sel_of(input logic [ENTRY_W-1:0] e);
    return (e[ENTRY_W-1 -: ID_BITS] != '0) && e[OIOL_SEL_BIT];
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[0][r] = win_r[0][r];
      nb[1][r] = win_r[1][r];
    end
    nb[2][0] = head_top;
    nb[2][1] = head_mid;
    nb[2][2] = head_bot;
  end

  always_comb begin
    cid  = id_of(nb[1][1]);
    csel = sel_of(nb[1][1]);
    gray = 1'b0;
    high = 1'b0;
    for (int c = 0; c < 3; c += 2) begin
      for (int r = 0; r < 3; r += 2) begin
        gray = gray | ((id_of(nb[c][r]) != '0) && (id_of(nb[c][r]) != cid));
      end
    end
    gray = gray && (cid != '0) && head_ctrl.row_in[1] && head_ctrl.col_in[1];
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (!(c == 1 && r == 1)) begin
          high = high | (sel_of(nb[c][r]) && head_ctrl.row_in[r] && head_ctrl.col_in[c]);
        end
      end
    end
    high = high && !csel;

    rgb = nb[1][1][OIOL_RGB_W-1:0];
    if (!look.outline_disable) begin
      if (high)      rgb = look.highlight_color;
      else if (gray) rgb = OIOL_GRAY_RGB;
    end
  end

  assign pop     = head_valid && (!out_valid_r || out_pix.ready);
  assign emit_go = pop && (head_ctrl.kind == QK_STEP) && head_ctrl.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      red_r       <= rgb[23:16];
      green_r     <= rgb[15:8];
      blue_r      <= rgb[7:0];
      frame_end_r <= head_ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head_ctrl.kind)
        QK_STEP: begin
          win_r[0] <= win_r[1];
          win_r[1][0] <= head_top;
          win_r[1][1] <= head_mid;
          win_r[1][2] <= head_bot;
        end
        QK_FIX_OLD: begin
          win_r[0][0] <= head_top;
          win_r[0][1] <= head_mid;
        end
        QK_FIX_NEW: begin
          win_r[1][0] <= head_top;
          win_r[1][1] <= head_mid;
        end
        default: ;
      endcase
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = red_r;
  assign out_pix.green_out = green_r;
  assign out_pix.blue_out  = blue_r;
  assign out_pix.frame_end = frame_end_r;

endmodule

/* rtl/core/object_id_outline_highlight.sv */
// Object-id outline and selection highlight over a raster pixel stream. The
// block takes one pixel per clock and sustains one result per clock while
// the queue has room and no window refill runs; each pixel leaves W+1
// accepted beats after it arrived (W = clamped frame width), then passes the
// history read register, the queue and the output register. W+1 is set by the
// history memory of 2*MAX_WIDTH+3 entries, written once and read at two
// addresses per beat, which rebuilds the 3x3 id window. A frame_width write
// starts a window refill (PR_OLD, PR_NEW) that takes no pixel. The history is
// not cleared after reset; only entries of the current frame reach the
// output. After the last pixel of a frame, W+1 flush beats push the rest out.
module object_id_outline_highlight import oiol_pkg::*; #(
  parameter int MAX_WIDTH = OIOL_MAX_WIDTH,
  parameter int ID_BITS   = OIOL_ID_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  oiol_pix_in_if.sink               in_pix,
  oiol_pix_out_if.source            out_pix,
  input  logic                      cfg_we,
  input  logic [OIOL_CFG_IDX_W-1:0] cfg_index,
  input  logic [OIOL_CFG_W-1:0]     cfg_data
);

  localparam int ENTRY_W = ID_BITS + OIOL_RGB_W + 1;
  localparam int Q_W     = $bits(oiol_ctrl_t) + 3 * ENTRY_W;
  localparam int CNT_W   = $clog2(OIOL_QDEPTH + 1);

  logic               f_valid;
  oiol_ctrl_t         f_ctrl;
  logic [ENTRY_W-1:0] f_top, f_mid, f_bot;
  oiol_look_t         look;

  logic [Q_W-1:0]     q_head;
  logic               q_valid, q_pop;
  logic [CNT_W-1:0]   q_count;

  oiol_ctrl_t         h_ctrl;
  logic [ENTRY_W-1:0] h_top, h_mid, h_bot;

  oiol_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_count    (q_count),
    .push_valid (f_valid),
    .push_ctrl  (f_ctrl),
    .push_top   (f_top),
    .push_mid   (f_mid),
    .push_bot   (f_bot),
    .look       (look)
  );

  oiol_queue #(
    .DATA_W (Q_W),
    .DEPTH  (OIOL_QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_data  ({f_ctrl, f_top, f_mid, f_bot}),
    .pop        (q_pop),
    .head_data  (q_head),
    .head_valid (q_valid),
    .count      (q_count)
  );

  assign {h_ctrl, h_top, h_mid, h_bot} = q_head;

  oiol_back #(
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_ctrl  (h_ctrl),
    .head_top   (h_top),
    .head_mid   (h_mid),
    .head_bot   (h_bot),
    .pop        (q_pop),
    .look       (look),
    .out_pix    (out_pix)
  );

endmodule

/* tb/object_id_outline_highlight_test.sv */
module object_id_outline_highlight_test;
  import oiol_pkg::*;

  localparam int HIST_LEN       = 2 * OIOL_MAX_WIDTH + 3;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEG_ITEMS      = 30;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [OIOL_CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_OUTLINE_OFF,
    REG_HIGHLIGHT
  } reg_index_t;

  typedef struct packed {
    logic [OIOL_ID_BITS-1:0] id;
    logic                    sel;
    logic [OIOL_RGB_W-1:0]   rgb;
  } hist_entry_t;

  typedef struct packed {
    logic [OIOL_ID_BITS-1:0] id;
    logic                    sel;
    logic [OIOL_RGB_W-1:0]   rgb;
    logic                    flush;
    logic                    typed;
    logic [OIOL_RGB_W-1:0]   want_rgb;
    logic                    want_end;
  } pix_item_t;

  typedef struct packed {
    logic [OIOL_RGB_W-1:0] rgb;
    logic                  frame_end;
  } px_out_t;

  // 3x3 frame around a selected interior centre, drained by four beats
  localparam pix_item_t DIRECTED_ROWS [13] = '{
    '{8'd1,  1'b0, 24'h102030, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{8'd0,  1'b0, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{8'd2,  1'b1, 24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{8'd0,  1'b0, 24'h808080, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{8'd3,  1'b1, 24'h112233, 1'b0, 1'b1, 24'h00FFFF, 1'b0},
    '{8'd3,  1'b1, 24'hAABBCC, 1'b0, 1'b1, 24'h00FFFF, 1'b0},
    '{8'd0,  1'b1, 24'h445566, 1'b0, 1'b1, 24'h000000, 1'b0},
    '{8'h5A, 1'b1, 24'h778899, 1'b1, 1'b1, 24'h00FFFF, 1'b0},
    '{8'hFF, 1'b0, 24'hFFFFFF, 1'b0, 1'b1, 24'h191919, 1'b0},
    '{8'd7,  1'b1, 24'h123456, 1'b1, 1'b1, 24'hAABBCC, 1'b0},
    '{8'd9,  1'b1, 24'hABCDEF, 1'b0, 1'b1, 24'h00FFFF, 1'b0},
    '{8'd0,  1'b0, 24'h000000, 1'b1, 1'b1, 24'h00FFFF, 1'b0},
    '{8'd0,  1'b0, 24'hFFFFFF, 1'b1, 1'b1, 24'h00FFFF, 1'b1}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [OIOL_CFG_IDX_W-1:0] cfg_index;
  logic [OIOL_CFG_W-1:0]     cfg_data;

  oiol_pix_in_if #(.ID_BITS(OIOL_ID_BITS)) pix_in ();
  oiol_pix_out_if                          pix_out ();

  object_id_outline_highlight dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_in),
    .out_pix   (pix_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wire in_beat  = pix_in.valid & pix_in.ready;
  wire out_beat = pix_out.valid & pix_out.ready;

  hist_entry_t           row_history [HIST_LEN];
  int                    col_pos;
  int                    row_pos;
  int                    slot;
  logic [OIOL_FW_W-1:0]  shadow_width;
  logic [OIOL_H_W-1:0]   shadow_height;
  logic                  shadow_outline_off;
  logic [OIOL_RGB_W-1:0] shadow_highlight;

  pix_item_t pending_pixels[$];
  px_out_t   expected_pixels[$];
  bit        in_busy;
  int        in_idle_pct;
  int        out_idle_pct;
  bit        hold_request;
  int        hold_left;
  int        quiet_cycles;
  int        mismatches;
  int        beats_in;
  int        pixels_checked;
  int        frames_seen;
  int        dropped_items;
  int        seg_items;
  pix_item_t accepted_item;
  bit        accepted_emit;
  px_out_t   accepted_result;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int eff_width();
    int v;
    v = int'(shadow_width);
    if (v < OIOL_MIN_SIZE) v = OIOL_MIN_SIZE;
    if (v > OIOL_MAX_WIDTH) v = OIOL_MAX_WIDTH;
    return v;
  endfunction

  function automatic int eff_height();
    int v;
    v = int'(shadow_height);
    if (v < OIOL_MIN_SIZE) v = OIOL_MIN_SIZE;
    if (v > OIOL_HEIGHT_LIMIT) v = OIOL_HEIGHT_LIMIT;
    return v;
  endfunction

  function automatic void reset_shadow();
    foreach (row_history[i]) row_history[i] = '0;
    col_pos = 0;
    row_pos = 0;
    slot = 0;
    shadow_width = OIOL_FW_W'(RESET_WIDTH);
    shadow_height = OIOL_H_W'(RESET_HEIGHT);
    shadow_outline_off = 1'b0;
    shadow_highlight = OIOL_HIGHLIGHT_RST;
  endfunction

  function automatic void apply_reg(input logic [OIOL_CFG_IDX_W-1:0] idx,
                                    input logic [OIOL_CFG_W-1:0] val);
    case (reg_index_t'(idx))
      REG_WIDTH:       shadow_width = val[OIOL_FW_W-1:0];
      REG_HEIGHT:      shadow_height = val[OIOL_H_W-1:0];
      REG_OUTLINE_OFF: shadow_outline_off = val[0];
      REG_HIGHLIGHT:   shadow_highlight = val[OIOL_RGB_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit is_selected(input hist_entry_t e);
    return e.id != '0 && e.sel;
  endfunction

  function automatic bit is_interior(input int r, input int c, input int w, input int h);
    return r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2;
  endfunction

  function automatic hist_entry_t window_at(input int er, input int ec, input int dy,
                                            input int dx, input int w, input int h,
                                            input int base);
    int r;
    int c;
    r = er + dy;
    c = ec + dx;
    if (r < 0 || r >= h || c < 0 || c >= w) return '0;
    return row_history[(base + dy * w + dx + HIST_LEN) % HIST_LEN];
  endfunction

  function automatic void shade_pixel(input pix_item_t p, output bit emit, output px_out_t res);
    int          w;
    int          h;
    int          er;
    int          ec;
    int          base;
    int          dy;
    int          dx;
    hist_entry_t e;
    hist_entry_t ctr;
    hist_entry_t q;
    bit          gray;
    bit          high;
    w = eff_width();
    h = eff_height();
    emit = 1'b0;
    res = '0;
    if (col_pos >= 1) begin
      er = row_pos - 1;
      ec = col_pos - 1;
    end else begin
      er = row_pos - 2;
      ec = w - 1;
    end
    // drop the beat and restart when the pixel due out lies beyond a shrunk frame
    if (er >= 0 && (er >= h || ec >= w)) begin
      row_pos = 0;
      col_pos = 0;
      slot = 0;
      dropped_items++;
      return;
    end
    e = '0;
    if (!p.flush && row_pos < h && col_pos < w) begin
      e.id = p.id;
      e.sel = p.sel;
      e.rgb = p.rgb;
    end
    row_history[slot] = e;
    if (er >= 0) begin
      base = (slot - (w + 1) + HIST_LEN) % HIST_LEN;
      ctr = row_history[base];
      res.rgb = ctr.rgb;
      if (!shadow_outline_off) begin
        gray = 1'b0;
        high = 1'b0;
        if (ctr.id != '0 && is_interior(er, ec, w, h)) begin
          for (dy = -1; dy <= 1; dy += 2) begin
            for (dx = -1; dx <= 1; dx += 2) begin
              q = window_at(er, ec, dy, dx, w, h, base);
              if (q.id != '0 && q.id != ctr.id) gray = 1'b1;
            end
          end
        end
        if (!is_selected(ctr)) begin
          for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
              if (dy != 0 || dx != 0) begin
                q = window_at(er, ec, dy, dx, w, h, base);
                if (is_selected(q) && is_interior(er + dy, ec + dx, w, h)) high = 1'b1;
              end
            end
          end
        end
        if (high) res.rgb = shadow_highlight;
        else if (gray) res.rgb = OIOL_GRAY_RGB;
      end
      res.frame_end = (er == h - 1 && ec == w - 1);
      emit = 1'b1;
    end
    if (res.frame_end) begin
      row_pos = 0;
      col_pos = 0;
      slot = 0;
    end else begin
      slot = (slot + 1) % HIST_LEN;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    end
  endfunction

  function automatic void check_pixel();
    px_out_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected pixel out: rgb %02h%02h%02h end %b", pix_out.red_out,
                 pix_out.green_out, pix_out.blue_out, pix_out.frame_end);
    end else begin
      want = expected_pixels.pop_front();
      if (pix_out.red_out !== want.rgb[23:16] || pix_out.green_out !== want.rgb[15:8] ||
          pix_out.blue_out !== want.rgb[7:0] || pix_out.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pixel %0d mismatch: expected rgb %06h end %b, got rgb %02h%02h%02h end %b",
                   pixels_checked, want.rgb, want.frame_end, pix_out.red_out,
                   pix_out.green_out, pix_out.blue_out, pix_out.frame_end);
      end
      pixels_checked++;
    end
    if (pix_out.frame_end === 1'b1) frames_seen++;
  endfunction

  function automatic pix_item_t random_pixel();
    pix_item_t p;
    p = '0;
    if ($urandom_range(99) < 75) p.id = OIOL_ID_BITS'($urandom_range(0, 3));
    else p.id = OIOL_ID_BITS'($urandom_range(0, 255));
    p.sel = ($urandom_range(99) < 25);
    p.rgb = OIOL_RGB_W'($urandom);
    p.flush = ($urandom_range(99) < 3);
    return p;
  endfunction

  task automatic queue_frame(input int w, input int h);
    pix_item_t p;
    for (int i = 0; i < w * h; i++) pending_pixels.push_back(random_pixel());
    for (int i = 0; i <= w; i++) begin
      p = random_pixel();
      p.flush = ($urandom_range(99) < 80);
      pending_pixels.push_back(p);
    end
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [OIOL_CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_busy || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    logic [OIOL_CFG_W-1:0] w_raw;
    logic [OIOL_CFG_W-1:0] h_raw;
    int                    roll;
    int                    nframes;
    wait_idle();
    roll = $urandom_range(99);
    if (roll < 8) w_raw = OIOL_CFG_W'($urandom_range(0, 2));
    else if (roll < 70) w_raw = OIOL_CFG_W'($urandom_range(3, 12));
    else if (roll < 90) w_raw = OIOL_CFG_W'($urandom_range(13, 40));
    else w_raw = OIOL_CFG_W'($urandom_range(41, 90));
    if ($urandom_range(3) == 0)
      w_raw[OIOL_CFG_W-1:OIOL_FW_W] = (OIOL_CFG_W - OIOL_FW_W)'($urandom);
    roll = $urandom_range(99);
    if (roll < 8) h_raw = OIOL_CFG_W'($urandom_range(0, 2));
    else if (roll < 85) h_raw = OIOL_CFG_W'($urandom_range(3, 8));
    else h_raw = OIOL_CFG_W'($urandom_range(9, 20));
    if ($urandom_range(3) == 0)
      h_raw[OIOL_CFG_W-1:OIOL_H_W] = (OIOL_CFG_W - OIOL_H_W)'($urandom);
    write_reg(REG_WIDTH, w_raw);
    write_reg(REG_HEIGHT, h_raw);
    if ($urandom_range(1) == 1)
      write_reg(REG_OUTLINE_OFF, (OIOL_CFG_W'($urandom) & ~OIOL_CFG_W'(1)) |
                                 OIOL_CFG_W'($urandom_range(99) < 20));
    if ($urandom_range(1) == 1) write_reg(REG_HIGHLIGHT, OIOL_CFG_W'($urandom));
    nframes = $urandom_range(1, 2);
    repeat (nframes) begin
      queue_frame(eff_width(), eff_height());
      seg_items += eff_width() * eff_height() + eff_width() + 1;
    end
  endtask

  // hold valid until the beat is taken
  always @(negedge clk) begin
    if (!in_busy) begin
      if (rst_n && pending_pixels.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        pix_in.object_id <= pending_pixels[0].id;
        pix_in.is_selected <= pending_pixels[0].sel;
        pix_in.red_in <= pending_pixels[0].rgb[23:16];
        pix_in.green_in <= pending_pixels[0].rgb[15:8];
        pix_in.blue_in <= pending_pixels[0].rgb[7:0];
        pix_in.flush <= pending_pixels[0].flush;
        pix_in.valid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (in_beat === 1'b1) begin
        accepted_item = pending_pixels.pop_front();
        in_busy = 1'b0;
        beats_in++;
        shade_pixel(accepted_item, accepted_emit, accepted_result);
        if (accepted_item.typed) begin
          accepted_result.rgb = accepted_item.want_rgb;
          accepted_result.frame_end = accepted_item.want_end;
          expected_pixels.push_back(accepted_result);
        end else if (accepted_emit) begin
          expected_pixels.push_back(accepted_result);
        end
      end
      if (out_beat === 1'b1) check_pixel();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_beat === 1'b1 || out_beat === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d pixels still expected",
               quiet_cycles, expected_pixels.size());
      $display("** object_id_outline_highlight: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_in.valid = 1'b0;
    pix_in.object_id = '0;
    pix_in.is_selected = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.flush = 1'b0;
    pix_out.ready = 1'b0;
    in_busy = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    mismatches = 0;
    beats_in = 0;
    pixels_checked = 0;
    frames_seen = 0;
    dropped_items = 0;
    in_idle_pct = 30;
    out_idle_pct = 68;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_WIDTH, OIOL_CFG_W'(3));
    write_reg(REG_HEIGHT, OIOL_CFG_W'(3));
    foreach (DIRECTED_ROWS[i]) pending_pixels.push_back(DIRECTED_ROWS[i]);
    wait_idle();

    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          in_idle_pct = 30;
          out_idle_pct = 68;
          // clamp sizes up from below, pass colors through
          write_reg(REG_WIDTH, 24'h000802);
          write_reg(REG_HEIGHT, 24'h002001);
          write_reg(REG_OUTLINE_OFF, 24'h000001);
          write_reg(REG_HIGHLIGHT, OIOL_CFG_W'($urandom));
          queue_frame(eff_width(), eff_height());
          wait_idle();
          write_reg(REG_OUTLINE_OFF, 24'hFFFFFE);
        end
        1: begin
          in_idle_pct = 68;
          out_idle_pct = 30;
          // shrink height mid-frame: next beat drops, then a fresh frame
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(8));
          write_reg(REG_HEIGHT, OIOL_CFG_W'(8));
          repeat (48) pending_pixels.push_back(random_pixel());
          wait_idle();
          write_reg(REG_HEIGHT, OIOL_CFG_W'(3));
          pending_pixels.push_back(random_pixel());
          queue_frame(8, 3);
          // shrink width mid-row
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(10));
          write_reg(REG_HEIGHT, OIOL_CFG_W'(6));
          repeat (25) pending_pixels.push_back(random_pixel());
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(4));
          pending_pixels.push_back(random_pixel());
          queue_frame(4, 6);
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
          // stall the output long enough to back up the input
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(12));
          write_reg(REG_HEIGHT, OIOL_CFG_W'(8));
          hold_request = 1'b1;
          queue_frame(12, 8);
          // clamp sizes down from the top of the register range
          wait_idle();
          write_reg(REG_WIDTH, 24'hFFFFFF);
          write_reg(REG_HEIGHT, OIOL_CFG_W'(3));
          write_reg(REG_OUTLINE_OFF, 24'hFFFFFE);
          write_reg(REG_HIGHLIGHT, OIOL_CFG_W'($urandom));
          repeat (eff_width() + 7) pending_pixels.push_back(random_pixel());
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(4));
          pending_pixels.push_back(random_pixel());
          queue_frame(4, 3);
          wait_idle();
          write_reg(REG_WIDTH, OIOL_CFG_W'(3));
          write_reg(REG_HEIGHT, 24'hFFFFFF);
          repeat (18) pending_pixels.push_back(random_pixel());
          wait_idle();
          write_reg(REG_HEIGHT, OIOL_CFG_W'(3));
          pending_pixels.push_back(random_pixel());
          queue_frame(3, 3);
        end
      endcase
      seg_items = 0;
      while (seg_items < SEG_ITEMS) random_phase();
    end

    wait_idle();
    $display("covered %0d frames: %0d pixels compared from %0d input beats",
             frames_seen, pixels_checked, beats_in);
    $display("sizes clamped up from below and down from the register top, outline on and off, %0d beats dropped",
             dropped_items);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("** object_id_outline_highlight: PASSED **");
    end else begin
      $display("%0d mismatches, %0d pixels never arrived", mismatches, expected_pixels.size());
      $display("** object_id_outline_highlight: FAILED **");
    end
    $finish;
  end

endmodule
